/* rtl/multichannel_encoder_tracker_core_defines.svh */
// assertion macros for the encoder tracker checker
// expects clk and rst in the scope where a macro is used
`ifndef MULTICHANNEL_ENCODER_TRACKER_CORE_DEFINES_SVH
`define MULTICHANNEL_ENCODER_TRACKER_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define MTE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mte same-cycle check failed");

// consequent checked in the next cycle
`define MTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mte next-cycle check failed");

`endif

/* rtl/mte_pkg.sv */
// shared types and constants for the multichannel encoder tracker
// no dependencies
`timescale 1ns / 1ps

package mte_pkg;

  localparam int CHANNELS = 8;
  localparam int RING_LEN = 5;

  localparam int CHAN_W  = 3;
  localparam int POS_W   = 13;
  localparam int TURN_W  = 18;
  localparam int FC_W    = 8;
  localparam int RATE_W  = 14;
  localparam int SPEED_W = 16;
  localparam int TOTAL_W = 32;
  localparam int DEG_W   = 27;

  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RING_DEPTH = CHANNELS * RING_LEN;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PTR_W      = $clog2(RING_LEN + 1);

  localparam int CPT_SHIFT    = POS_W;
  localparam int DEG_PER_TURN = 360;
  localparam int DEGP_W       = TOTAL_W + 10;

  localparam int SUM_W       = $clog2(RING_LEN * 5000 + 1) + 1;
  localparam int MAG_W       = SUM_W - 1;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = (1 << RECIP_SHIFT) / RING_LEN;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = MAG_W + RECIP_W;

  localparam logic signed [POS_W:0]   WRAP_LIMIT = 5000;
  localparam logic signed [POS_W+1:0] COUNTS_PER_TURN = 15'sd8192;
  localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
  localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
  localparam logic [DEGP_W-1:0] DEG_BIAS = DEGP_W'((1 << CPT_SHIFT) - 1);

  typedef enum logic {
    OP_FRAME  = 1'b0,
    OP_REZERO = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_SUM,
    S_SCALE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         zero_offset;
    logic signed [TURN_W-1:0] turn_count;
    logic [FC_W-1:0]          frame_count;
    logic [PTR_W-1:0]         ring_pointer;
  } chan_state_t;

  localparam int CHAN_STATE_W = $bits(chan_state_t);

  typedef struct packed {
    chan_state_t              state;
    logic signed [RATE_W-1:0] rate;
    logic                     calib;
    logic                     ring_wr;
    logic [PTR_W-1:0]         ring_slot;
  } upd_t;

endpackage

/* rtl/mte_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/mte_step_calc.sv */
// per-channel state update for one word: rezero, capture, unwrap, turn count, ring slot
// depends on mte_pkg
`timescale 1ns / 1ps

module mte_step_calc import mte_pkg::*; (
  input  op_t               op,
  input  logic [POS_W-1:0]  encoder_count,
  input  logic [FC_W-1:0]   calib_frames,
  input  chan_state_t       cur,
  output upd_t              upd
);

  logic signed [POS_W:0]   diff;
  logic signed [POS_W+1:0] diff_w;
  logic [PTR_W-1:0]        slot;

  always_comb begin
    diff   = $signed({1'b0, encoder_count}) - $signed({1'b0, cur.position});
    diff_w = {diff[POS_W], diff};
    slot   = (cur.ring_pointer >= PTR_W'(RING_LEN)) ? '0 : cur.ring_pointer;

    upd           = '0;
    upd.state     = cur;
    upd.calib     = cur.frame_count < calib_frames;
    upd.ring_slot = slot;

    if (op == OP_REZERO) begin
      upd.state.turn_count  = '0;
      upd.state.zero_offset = cur.position;
    end else if (upd.calib) begin
      upd.state.frame_count = cur.frame_count + 1'b1;
      upd.state.position    = encoder_count;
      upd.state.zero_offset = encoder_count;
    end else begin
      upd.state.position = encoder_count;
      upd.ring_wr        = 1'b1;
      if (diff > WRAP_LIMIT) begin
        if (cur.turn_count > TURN_MIN) begin
          upd.state.turn_count = cur.turn_count - 1'b1;
        end
        upd.rate = RATE_W'(diff_w - COUNTS_PER_TURN);
      end else if (diff < -WRAP_LIMIT) begin
        if (cur.turn_count < TURN_MAX) begin
          upd.state.turn_count = cur.turn_count + 1'b1;
        end
        upd.rate = RATE_W'(diff_w + COUNTS_PER_TURN);
      end else begin
        upd.rate = RATE_W'(diff_w);
      end
      if (slot == PTR_W'(RING_LEN - 1)) begin
        upd.state.ring_pointer = '0;
      end else begin
        upd.state.ring_pointer = slot + 1'b1;
      end
    end
  end

endmodule

/* rtl/multichannel_encoder_tracker_core.sv */
// multichannel encoder tracker, top level
// depends on mte_pkg, mte_ram, mte_step_calc
//
// input channel: in_valid/in_ready carry one word (op, channel, encoder_count,
// speed_in); op 0 is a feedback frame, op 1 rezeroes the channel
// output channel: out_valid/out_ready carry one result word per input word
// config: cfg_wr_en writes cfg_wr_data into calib_frames at once
// one word passes from acceptance to the next acceptance through these steps:
// channel state read, update and write-back, then one read per ring entry
// of the ring memory, then the mean and degree scaling; the ring read port
// sets the length of this sequence
// out_valid is registered and rises when the final step loads the result
// the result register lets the next word be taken while a result waits;
// a stalled receiver holds the block in its final step until taken
// reset clears all channel state through valid bits, so no clearing pass
// is needed; calib_frames resets to 51
`timescale 1ns / 1ps

module multichannel_encoder_tracker_core import mte_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [CHAN_W-1:0]          channel,
  input  logic [POS_W-1:0]           encoder_count,
  input  logic signed [SPEED_W-1:0]  speed_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CHAN_W-1:0]          channel_out,
  output logic                       calibrating,
  output logic signed [SPEED_W-1:0]  speed_out,
  output logic signed [RATE_W-1:0]   step_rate,
  output logic signed [RATE_W-1:0]   mean_rate,
  output logic signed [TOTAL_W-1:0]  total_count,
  output logic signed [DEG_W-1:0]    total_degrees,
  input  logic                       cfg_wr_en,
  input  logic [FC_W-1:0]            cfg_wr_data
);

  state_t state, state_next;
  logic [FC_W-1:0] calib_frames;

  op_t                      op_q;
  logic [CHAN_W-1:0]        ch_q;
  logic [POS_W-1:0]         enc_q;
  logic signed [SPEED_W-1:0] speed_q;

  logic [CHANNELS-1:0]   chan_vld;
  logic [RING_DEPTH-1:0] ring_vld;
  logic                  chan_rd_ok;
  logic                  ring_rd_ok;

  logic in_acc, ch_ok, load_out;
  logic chan_rd_en, chan_wr_en, ring_rd_en, ring_wr_en;

  logic [CH_AW-1:0]        ch_in_addr, ch_addr;
  logic [CHAN_STATE_W-1:0] chan_rdata;
  chan_state_t             chan_cur;
  upd_t                    upd, upd_q;

  logic [RING_AW-1:0]      ring_base, ring_wr_addr, ring_rd_addr;
  logic [RATE_W-1:0]       ring_rdata;
  logic [PTR_W-1:0]        idx;
  logic signed [SUM_W-1:0] sum_q;

  logic signed [TOTAL_W-1:0] turn_ext, total_calc, total_q;
  logic [MAG_W-1:0]          mag, mag_q, q_est, q_fix, rem;
  logic                      sum_neg_q;
  logic [PROD_W-1:0]         prod_q;
  logic signed [DEGP_W-1:0]  deg_prod_q, deg_biased;
  logic signed [RATE_W-1:0]  mean_calc;

  assign ch_in_addr = CH_AW'(channel);
  assign ch_addr    = CH_AW'(ch_q);
  assign ch_ok      = (32'(channel) < CHANNELS);
  assign in_acc     = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && ch_ok) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: state_next = S_UPDATE;
      S_UPDATE: state_next = S_SUM;
      S_SUM: begin
        if (idx == PTR_W'(RING_LEN)) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    chan_rd_en = 1'b0;
    chan_wr_en = 1'b0;
    ring_rd_en = 1'b0;
    ring_wr_en = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        chan_rd_en = in_valid;
      end
      S_UPDATE: begin
        chan_wr_en = 1'b1;
        ring_wr_en = upd_q.ring_wr;
      end
      S_SUM: ring_rd_en = (idx < PTR_W'(RING_LEN));
      S_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  mte_ram #(
    .WIDTH(CHAN_STATE_W),
    .DEPTH(CHANNELS)
  ) u_chan_ram (
    .clk    (clk),
    .wr_en  (chan_wr_en),
    .wr_addr(ch_addr),
    .wr_data(upd_q.state),
    .rd_en  (chan_rd_en),
    .rd_addr(ch_in_addr),
    .rd_data(chan_rdata)
  );

  assign ring_wr_addr = ring_base + RING_AW'(upd_q.ring_slot);
  assign ring_rd_addr = ring_base + RING_AW'(idx);

  mte_ram #(
    .WIDTH(RATE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring_ram (
    .clk    (clk),
    .wr_en  (ring_wr_en),
    .wr_addr(ring_wr_addr),
    .wr_data(upd_q.rate),
    .rd_en  (ring_rd_en),
    .rd_addr(ring_rd_addr),
    .rd_data(ring_rdata)
  );

  assign chan_cur = chan_rd_ok ? chan_state_t'(chan_rdata) : '0;

  mte_step_calc u_step (
    .op           (op_q),
    .encoder_count(enc_q),
    .calib_frames (calib_frames),
    .cur          (chan_cur),
    .upd          (upd)
  );

  always_comb begin
    turn_ext   = TOTAL_W'(upd_q.state.turn_count);
    total_calc = (turn_ext <<< CPT_SHIFT) + $signed(TOTAL_W'(upd_q.state.position))
                 - $signed(TOTAL_W'(upd_q.state.zero_offset));
    mag        = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
    q_est      = MAG_W'(prod_q >> RECIP_SHIFT);
    rem        = mag_q - MAG_W'(q_est * RING_LEN);
    q_fix      = (rem >= MAG_W'(RING_LEN)) ? q_est + 1'b1 : q_est;
    mean_calc  = sum_neg_q ? -RATE_W'(q_fix) : RATE_W'(q_fix);
    deg_biased = deg_prod_q + (deg_prod_q[DEGP_W-1] ? $signed(DEG_BIAS) : '0);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      calib_frames <= FC_W'(51);
      chan_vld     <= '0;
      ring_vld     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        calib_frames <= cfg_wr_data;
      end
      if (chan_wr_en) begin
        chan_vld[ch_addr] <= 1'b1;
      end
      if (ring_wr_en) begin
        ring_vld[ring_wr_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q       <= op_t'(op);
      ch_q       <= channel;
      enc_q      <= encoder_count;
      speed_q    <= speed_in;
      chan_rd_ok <= chan_vld[ch_in_addr];
    end
    if (state == S_LOOKUP) begin
      upd_q     <= upd;
      ring_base <= RING_AW'(32'(ch_q) * RING_LEN);
    end
    if (state == S_UPDATE) begin
      total_q <= total_calc;
      idx     <= '0;
      sum_q   <= '0;
    end
    if (state == S_SUM) begin
      idx <= idx + 1'b1;
      if (ring_rd_en) begin
        ring_rd_ok <= ring_vld[ring_rd_addr];
      end
      if (idx != '0 && ring_rd_ok) begin
        sum_q <= sum_q + SUM_W'($signed(ring_rdata));
      end
    end
    if (state == S_SCALE) begin
      mag_q      <= mag;
      sum_neg_q  <= sum_q[SUM_W-1];
      prod_q     <= PROD_W'(mag) * PROD_W'(RECIP);
      deg_prod_q <= DEGP_W'(total_q) * $signed(DEGP_W'(DEG_PER_TURN));
    end
    if (load_out) begin
      channel_out   <= ch_q;
      calibrating   <= upd_q.calib;
      speed_out     <= speed_q;
      step_rate     <= upd_q.rate;
      mean_rate     <= mean_calc;
      total_count   <= total_q;
      total_degrees <= DEG_W'(deg_biased >>> CPT_SHIFT);
    end
  end

endmodule

/* rtl/mte_checker.sv */
// port-level checks for the encoder tracker, bound to the top level
// depends on mte_pkg and multichannel_encoder_tracker_core_defines.svh
`timescale 1ns / 1ps
`include "multichannel_encoder_tracker_core_defines.svh"

module mte_checker import mte_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [CHAN_W-1:0]          channel_out,
  input logic                       calibrating,
  input logic signed [RATE_W-1:0]   step_rate,
  input logic signed [RATE_W-1:0]   mean_rate,
  input logic signed [TOTAL_W-1:0]  total_count
);

  `MTE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable({channel_out, total_count}))
  `MTE_ASSERT_SAME(a_calib_no_step, out_valid && calibrating, step_rate == '0)
  `MTE_ASSERT_SAME(a_step_range, out_valid, (step_rate <= 14'sd5000) && (step_rate >= -14'sd5000))
  `MTE_ASSERT_SAME(a_mean_range, out_valid, (mean_rate <= 14'sd5000) && (mean_rate >= -14'sd5000))

endmodule

bind multichannel_encoder_tracker_core mte_checker u_mte_checker (.*);
